FILE: rtl/sbl_pkg.sv
package sbl_pkg;

   // Number of cells in the row, and the widths that follow from it
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic signed [7:0] sbl_byte_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } sbl_op_type;

   // Broadcast to every cell in the row
   typedef struct packed {
      logic         ins;
      logic         rem;
      sbl_byte_type value;
   } sbl_ctrl_type;

endpackage

FILE: rtl/sbl_cell.sv
module sbl_cell
   import sbl_pkg::*;
(
   input  logic         clock,
   input  sbl_ctrl_type ctrl,
   input  logic         occupied,
   input  sbl_byte_type left_entry,
   input  logic         left_less,
   input  sbl_byte_type right_entry,
   output sbl_byte_type entry,
   output sbl_byte_type entry_next,
   output logic         less,
   output logic         eq
);

   sbl_byte_type entry_ff;
   sbl_byte_type entry_in;

   assign less = occupied && (entry_ff < ctrl.value);
   assign eq   = occupied && (entry_ff == ctrl.value);

   // Cells below the insert/remove point hold; the rest shift one place
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && !less) begin
         entry_in = left_less ? ctrl.value : left_entry;
      end else if (ctrl.rem && !less) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

FILE: rtl/sorted_byte_list_unit.sv
// A result is registered and offered in the cycle after its item is accepted.
// Throughput: one item per cycle while the result side is not stalling; each item makes a single compare-and-shift pass
// across the row of CAPACITY cells, and the next item sees the updated row.
// Reset (synchronous, active high) empties the list and drops any pending result;
// the cell entry registers are not reset, since entries at or past the count are unused.
module sorted_byte_list_unit
   import sbl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic signed [7:0]   req_value,
   input  logic [3:0]          req_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic signed [7:0]   rsp_read_value,
   output logic [4:0]          rsp_size,
   output logic signed [7:0]   rsp_largest
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_ok_ff;
   logic             rsp_ok_in;
   sbl_byte_type     rsp_read_ff;
   sbl_byte_type     rsp_read_in;
   logic [4:0]       rsp_size_ff;
   logic [4:0]       rsp_size_in;
   sbl_byte_type     rsp_largest_ff;
   sbl_byte_type     rsp_largest_in;

   logic             accept;
   sbl_op_type       op;
   sbl_ctrl_type     ctrl;
   logic             found;
   logic             ins_ok;
   logic             rem_ok;
   logic             rd_ok;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] last_idx;

   sbl_byte_type     cell_entry [CAPACITY];
   sbl_byte_type     cell_next  [CAPACITY];
   logic [CAPACITY-1:0] cell_less;
   logic [CAPACITY-1:0] cell_eq;

   // Take a new item whenever the output register is empty or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = sbl_op_type'(req_operation);
   assign rd_idx    = IDX_W'(req_position);

   // Any occupied cell equal to the value means the remove can proceed
   assign found = |cell_eq;

   always_comb begin
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      rd_ok  = 1'b0;
      case (op)
         OP_INSERT: ins_ok = (count_ff < CNT_W'(CAPACITY));
         OP_REMOVE: rem_ok = found;
         OP_READ:   rd_ok  = ({1'b0, req_position} < 5'(count_ff));
         default:   ;
      endcase
   end

   // Broadcast the operation to every cell; cells move only on a successful item
   assign ctrl.ins   = accept && ins_ok;
   assign ctrl.rem   = accept && rem_ok;
   assign ctrl.value = req_value;

   // Row of compare-and-shift cells: each sees its neighbors' entries and
   // the left neighbor's compare result
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sbl_byte_type left_entry;
      logic         left_less;
      sbl_byte_type right_entry;
      logic         occupied;

      if (i == 0) begin : g_first
         assign left_entry = req_value;
         assign left_less  = 1'b1;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
         assign left_less  = cell_less[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      assign occupied = (CNT_W'(i) < count_ff);

      sbl_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .entry_next  (cell_next[i]),
         .less        (cell_less[i]),
         .eq          (cell_eq[i])
      );
   end

   // Advance the count; it only moves with a successful insert or remove
   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Largest entry is the last occupied cell after the update
   assign last_idx = IDX_W'(count_in - CNT_W'(1));

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_read_in    = rsp_read_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_largest_in = rsp_largest_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = ins_ok || rem_ok || rd_ok;
         rsp_read_in    = rd_ok ? cell_entry[rd_idx] : '0;
         rsp_size_in    = 5'(count_in);
         rsp_largest_in = (count_in == '0) ? '0 : cell_next[last_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until it is taken
   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_largest_ff <= rsp_largest_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_size       = rsp_size_ff;
   assign rsp_largest    = rsp_largest_ff;

   // The list never holds more entries than there are cells
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Every accepted item leaves a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // A failed item leaves the size unchanged
   assert property (@(posedge clock) disable iff (reset)
      (accept && !(ins_ok || rem_ok)) |=> (count_ff == $past(count_ff)))
      else $error("size changed on a failed item");

   // A reported size always matches the count left by that item
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_size_ff == 5'(count_ff)))
      else $error("reported size differs from stored count");

endmodule

FILE: tb/sv/sorted_byte_list_checker.sv
module sorted_byte_list_checker
   import sbl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [7:0]  req_value,
   input  logic [3:0]         req_position,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_ok,
   input  logic signed [7:0]  rsp_read_value,
   input  logic [4:0]         rsp_size,
   input  logic signed [7:0]  rsp_largest,
   output int                 fail_count,
   output int                 outstanding,
   output int                 checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               ok;
      sbl_byte_type       read_value;
      logic [CNT_W-1:0]   size;
      sbl_byte_type       largest;
   } list_outcome_type;

   sbl_byte_type     shadow_row [CAPACITY];
   int               shadow_count;
   list_outcome_type outcome_q [$];
   int               bad_results;
   int               results_seen;

   // Update the shadow list with one item and return the result it must produce.
   function automatic list_outcome_type apply_list_op(input logic [1:0] op,
                                                      input sbl_byte_type v,
                                                      input logic [3:0] pos);
      list_outcome_type r;
      int               slot;
      int               i;
      r    = '0;
      slot = 0;
      case (op)
         OP_INSERT: begin
            if (shadow_count < CAPACITY) begin
               while (slot < shadow_count && shadow_row[slot] < v) slot++;
               for (i = shadow_count; i > slot; i--) shadow_row[i] = shadow_row[i-1];
               shadow_row[slot] = v;
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            while (slot < shadow_count && shadow_row[slot] < v) slot++;
            if (slot < shadow_count && shadow_row[slot] == v) begin
               for (i = slot; i < shadow_count - 1; i++) shadow_row[i] = shadow_row[i+1];
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         OP_READ: begin
            if (pos < shadow_count) begin
               r.read_value = shadow_row[pos];
               r.ok         = 1'b1;
            end
         end
         default: ;
      endcase
      r.size    = shadow_count[CNT_W-1:0];
      r.largest = (shadow_count > 0) ? shadow_row[shadow_count-1] : 8'sd0;
      return r;
   endfunction

   always @(posedge clock) begin
      list_outcome_type want;
      list_outcome_type got;
      if (reset) begin
         shadow_count = 0;
         outcome_q.delete();
      end else begin
         // Retire a result before taking this edge's item: a result never leaves in the cycle its item is taken.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_ok, rsp_read_value, rsp_size, rsp_largest};
            results_seen++;
            if (outcome_q.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("[%0t] unexpected result: ok=%0b read=%0d size=%0d largest=%0d",
                           $time, got.ok, got.read_value, got.size, got.largest);
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display({"[%0t] result %0d mismatch: expected ok=%0b read=%0d size=%0d ",
                               "largest=%0d, got ok=%0b read=%0d size=%0d largest=%0d"},
                              $time, results_seen, want.ok, want.read_value, want.size,
                              want.largest, got.ok, got.read_value, got.size, got.largest);
               end
            end
         end
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_list_op(req_operation, req_value, req_position));
      end
      fail_count  <= bad_results;
      outstanding <= outcome_q.size();
      checked     <= results_seen;
   end

endmodule

FILE: tb/sv/sorted_byte_list_unit_tb.sv
module sorted_byte_list_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbl_pkg::*;

   // Operation code with no meaning: the block must answer it with a failed result
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         ITEM_GOAL  = 1550;
   // Keep both sides busy for the last stretch of items
   localparam int         CALM_TAIL  = 200;
   // Byte extremes and neighbors of zero; a small pool so removes hit often
   localparam sbl_byte_type CORNER_VALUES [8] = '{8'h80, 8'h81, 8'hFE, 8'hFF,
                                                  8'h00, 8'h01, 8'h7E, 8'h7F};

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} phase_mix_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation  = OP_INSERT;
   logic signed [7:0]  req_value      = 8'sd0;
   logic [3:0]         req_position   = 4'd0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic               rsp_ok;
   logic signed [7:0]  rsp_read_value;
   logic [4:0]         rsp_size;
   logic signed [7:0]  rsp_largest;

   int fail_count;
   int outstanding;
   int checked;

   bit idle_req = 1'b0;
   bit idle_rsp = 1'b0;
   int items_sent = 0;
   int sent_per_op [4] = '{0, 0, 0, 0};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_byte_list_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_size       (rsp_size),
      .rsp_largest    (rsp_largest)
   );

   sorted_byte_list_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_size       (rsp_size),
      .rsp_largest    (rsp_largest),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .checked        (checked)
   );

   // Offer one item and hold it until the block takes it. When idling is on,
   // sometimes drop valid for a random burst first. Returns at the accepting edge, so the
   // next call drives its item in the same step without a second assignment.
   task automatic send_item(input logic [1:0] op, input sbl_byte_type v, input logic [3:0] pos);
      int gap;
      if (idle_req && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      req_position  <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_per_op[op]++;
      items_sent++;
   endtask

   // Pick a byte: either one of the corner values or anything at all
   function automatic sbl_byte_type pick_value(input bit corner);
      logic [7:0] raw;
      raw = $urandom_range(0, 255);
      if (corner)
         return CORNER_VALUES[$urandom_range(0, 7)];
      return raw;
   endfunction

   // Bias the operation mix by phase: fill phases push the list to full and
   // past it, drain phases empty it and then remove from an empty list
   function automatic logic [1:0] pick_op(input phase_mix_type mix);
      int roll;
      int ins_cut;
      int rem_cut;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin ins_cut = 65; rem_cut = 75; end
         MIX_DRAIN: begin ins_cut = 10; rem_cut = 70; end
         default:   begin ins_cut = 35; rem_cut = 68; end
      endcase
      if (roll < ins_cut) return OP_INSERT;
      if (roll < rem_cut) return OP_REMOVE;
      if (roll < 96)      return OP_READ;
      return OP_UNUSED;
   endfunction

   // Result side: stall in random bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idle_rsp && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      phase_mix_type mix;
      bit            corner;
      bit            calm;
      int            phase_len;
      int            phases;
      logic [1:0]    op;
      sbl_byte_type  val;
      sbl_byte_type  recent_ins [16];
      logic [3:0]    recent_wr;

      phases    = 0;
      recent_wr = 4'd0;
      foreach (recent_ins[i]) recent_ins[i] = 8'sd0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: read, remove and the unused code all fail
      send_item(OP_READ,   8'sd0,  4'd0);
      send_item(OP_REMOVE, 8'sd0,  4'd0);
      send_item(OP_UNUSED, 8'h7F,  4'd15);
      // Extremes, a duplicate, and a value between
      send_item(OP_INSERT, 8'h7F,  4'd0);
      send_item(OP_INSERT, 8'h80,  4'd0);
      send_item(OP_INSERT, 8'sd0,  4'd0);
      send_item(OP_INSERT, 8'sd0,  4'd7);
      send_item(OP_INSERT, 8'hFF,  4'd0);
      // Reads: first, last, at the count and far past it
      send_item(OP_READ,   8'sd0,  4'd0);
      send_item(OP_READ,   8'sd0,  4'd4);
      send_item(OP_READ,   8'sd0,  4'd5);
      send_item(OP_READ,   8'h80,  4'd15);
      send_item(OP_UNUSED, 8'h80,  4'd2);
      // Remove an absent value, then the largest, so largest falls back
      send_item(OP_REMOVE, 8'sd5,  4'd0);
      send_item(OP_REMOVE, 8'h7F,  4'd0);
      send_item(OP_REMOVE, 8'sd0,  4'd0);
      send_item(OP_REMOVE, 8'h80,  4'd0);
      send_item(OP_REMOVE, 8'hFF,  4'd0);
      // Last entry gone: largest returns to zero
      send_item(OP_REMOVE, 8'sd0,  4'd0);
      send_item(OP_READ,   8'sd0,  4'd0);

      // Random phases, each with its own mix, value pool and idling
      while (items_sent < ITEM_GOAL) begin
         mix       = phase_mix_type'($urandom_range(0, 2));
         corner    = ($urandom_range(0, 9) < 6);
         phase_len = $urandom_range(40, 120);
         calm      = (items_sent >= ITEM_GOAL - CALM_TAIL);
         idle_req <= !calm && ($urandom_range(0, 3) != 0);
         idle_rsp <= !calm && ($urandom_range(0, 3) != 0);
         phases++;
         repeat (phase_len) begin
            op  = pick_op(mix);
            val = pick_value(corner);
            // Aim half the removes at something inserted lately
            if (op == OP_REMOVE && $urandom_range(0, 1) == 1)
               val = recent_ins[$urandom_range(0, 15)];
            if (op == OP_INSERT) begin
               recent_ins[recent_wr] = val;
               recent_wr++;
            end
            send_item(op, val, 4'($urandom_range(0, 15)));
         end
      end

      req_valid <= 1'b0;
      // Wait out every result still owed, then allow the block's latency
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("run covered %0d items over %0d random phases: %0d inserts, %0d removes,",
               items_sent, phases, sent_per_op[OP_INSERT], sent_per_op[OP_REMOVE]);
      $display("%0d reads, %0d unused codes; %0d results compared, %0d failures",
               sent_per_op[OP_READ], sent_per_op[OP_UNUSED], checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** sorted_byte_list_unit: PASSED **");
      end else begin
         $display("** sorted_byte_list_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #400_000;
      $display("watchdog expired with %0d results outstanding", outstanding);
      $display("** sorted_byte_list_unit: FAILED **");
      $finish;
   end

endmodule
